/* src/frm_pkg.sv */
// Frame rate meter package: field widths, constants, controller states and
// the command and status structs shared by the controller and the datapath.
// Depends on nothing.
package frm_pkg;

   localparam int RING_DEPTH_DEF = 16;

   localparam int ELAPSED_W = 24;
   localparam int RATE_W = 28;
   localparam int TIME_W = 48;
   localparam int TOTAL_W = 32;

   // Three bytes carry the elapsed time; the pause flag travels in tuser.
   localparam int REQ_DATA_W = 24;
   // rate (28) + game time (48) + frame total (32) = 108, padded to 112.
   localparam int RSP_USED_W = RATE_W + TIME_W + TOTAL_W;
   localparam int RSP_DATA_W = ((RSP_USED_W + 7) / 8) * 8;

   // One second in microseconds, scaled by 256 for the Q20.8 result.
   localparam logic [RATE_W-1:0] RATE_NUMERATOR = RATE_W'(256000000);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RATE_START,
      ST_RATE_WAIT,
      ST_RING_UPDATE,
      ST_MEAN_CHECK,
      ST_MEAN_WAIT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic accept;      // latch the tick, advance game clock and tick count
      logic rate_start;  // start sample division, read the ring slot
      logic ring_update; // write the sample, update sum, count and slot
      logic mean_start;  // start division of the sum by the filled count
      logic load_held;   // take the mean as the held rate
      logic load_out;    // move the result into the output register
   } cmd_type;

   typedef struct packed {
      logic elapsed_zero;
      logic filled_nonzero;
      logic div_done;
      logic out_free;
   } sts_type;

endpackage

/* src/frm_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
// Uses no package; instantiated by the frame rate meter datapath.
module frm_div #(
   parameter int NUM_W = 33,
   parameter int DEN_W = 24
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [NUM_W-1:0] quo,
   output logic             done
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   trial;
   logic [DEN_W+1:0] diff;

   assign trial = {rem_ff, quo_ff[NUM_W-1]};
   assign diff = {1'b0, trial} - {2'b00, den_ff};

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = num;
         rem_in = '0;
         den_in = den;
         cnt_in = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // A clear sign bit means the shifted remainder holds the divisor.
         if (!diff[DEN_W+1]) begin
            rem_in = diff[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quo = quo_ff;
   assign done = done_ff;

endmodule

/* src/frm_dpath.sv */
// Frame rate meter datapath: sample ring, running sum, clocks, shared divider
// and output register. Depends on frm_pkg and frm_div.
module frm_dpath #(
   parameter int RING_DEPTH = frm_pkg::RING_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  frm_pkg::cmd_type                 cmd,
   output frm_pkg::sts_type                 sts,
   input  logic [frm_pkg::ELAPSED_W-1:0]    req_elapsed_us,
   input  logic                             req_paused,
   input  logic                             rsp_tready,
   output logic                             rsp_tvalid,
   output logic [frm_pkg::RATE_W-1:0]       rsp_rate_q8,
   output logic [frm_pkg::TIME_W-1:0]       rsp_game_time_us,
   output logic [frm_pkg::TOTAL_W-1:0]      rsp_frame_total
);

   import frm_pkg::*;

   localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int CNT_W = $clog2(RING_DEPTH + 1);
   localparam int SUM_W = RATE_W + $clog2(RING_DEPTH + 1);

   logic [RATE_W-1:0]    ring_mem [RING_DEPTH];
   logic [RING_DEPTH-1:0] valid_ff;
   logic [RATE_W-1:0]    old_q_ff;
   logic                 old_valid_ff;
   logic [RATE_W-1:0]    old_rate;

   logic [ELAPSED_W-1:0] elapsed_ff;
   logic [IDX_W-1:0]     slot_ff, slot_in;
   logic [CNT_W-1:0]     filled_ff;
   logic [SUM_W-1:0]     sum_ff;
   logic [RATE_W-1:0]    held_ff;
   logic [TIME_W-1:0]    clock_ff;
   logic [TOTAL_W-1:0]   ticks_ff;

   logic                 out_valid_ff;
   logic [RATE_W-1:0]    out_rate_ff;
   logic [TIME_W-1:0]    out_time_ff;
   logic [TOTAL_W-1:0]   out_total_ff;

   logic                 div_start;
   logic [SUM_W-1:0]     div_num;
   logic [ELAPSED_W-1:0] div_den;
   logic [SUM_W-1:0]     div_quo;
   logic                 div_done;

   assign div_start = cmd.rate_start | cmd.mean_start;
   assign div_num = cmd.rate_start ? SUM_W'(RATE_NUMERATOR) : sum_ff;
   assign div_den = cmd.rate_start ? elapsed_ff : ELAPSED_W'(filled_ff);

   frm_div #(
      .NUM_W(SUM_W),
      .DEN_W(ELAPSED_W)
   ) u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .num(div_num),
      .den(div_den),
      .quo(div_quo),
      .done(div_done)
   );

   // An entry that was never written since reset reads as empty.
   assign old_rate = old_valid_ff ? old_q_ff : '0;
   assign slot_in = (slot_ff == IDX_W'(RING_DEPTH - 1)) ? '0 : slot_ff + IDX_W'(1);

   always_ff @(posedge clock) begin
      if (cmd.rate_start) begin
         old_q_ff <= ring_mem[slot_ff];
      end
      if (cmd.ring_update) begin
         ring_mem[slot_ff] <= div_quo[RATE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         elapsed_ff <= req_elapsed_us;
      end
      if (cmd.load_out) begin
         out_rate_ff <= held_ff;
         out_time_ff <= clock_ff;
         out_total_ff <= ticks_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         old_valid_ff <= 1'b0;
         slot_ff <= '0;
         filled_ff <= '0;
         sum_ff <= '0;
         held_ff <= '0;
         clock_ff <= '0;
         ticks_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.accept) begin
            if (!req_paused) begin
               clock_ff <= clock_ff + TIME_W'(req_elapsed_us);
            end
            ticks_ff <= ticks_ff + TOTAL_W'(1);
         end
         if (cmd.rate_start) begin
            old_valid_ff <= valid_ff[slot_ff];
         end
         if (cmd.ring_update) begin
            valid_ff[slot_ff] <= 1'b1;
            sum_ff <= sum_ff - SUM_W'(old_rate) + SUM_W'(div_quo[RATE_W-1:0]);
            if (!old_valid_ff) begin
               filled_ff <= filled_ff + CNT_W'(1);
            end
            slot_ff <= slot_in;
         end
         if (cmd.load_held) begin
            held_ff <= div_quo[RATE_W-1:0];
         end
         if (cmd.load_out) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      sts.elapsed_zero = (elapsed_ff == '0);
      sts.filled_nonzero = (filled_ff != '0);
      sts.div_done = div_done;
      sts.out_free = !out_valid_ff || rsp_tready;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_rate_q8 = out_rate_ff;
   assign rsp_game_time_us = out_time_ff;
   assign rsp_frame_total = out_total_ff;

endmodule

/* src/frm_ctrl.sv */
// Frame rate meter controller: sequences one tick through the datapath.
// Depends on frm_pkg.
module frm_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  frm_pkg::sts_type sts,
   output frm_pkg::cmd_type cmd
);

   import frm_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_RATE_START;
         end
         ST_RATE_START: begin
            state_in = sts.elapsed_zero ? ST_MEAN_CHECK : ST_RATE_WAIT;
         end
         ST_RATE_WAIT: begin
            if (sts.div_done) state_in = ST_RING_UPDATE;
         end
         ST_RING_UPDATE: begin
            state_in = ST_MEAN_CHECK;
         end
         ST_MEAN_CHECK: begin
            state_in = sts.filled_nonzero ? ST_MEAN_WAIT : ST_EMIT;
         end
         ST_MEAN_WAIT: begin
            if (sts.div_done) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (sts.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         ST_RATE_START: begin
            cmd.rate_start = !sts.elapsed_zero;
         end
         ST_RATE_WAIT: begin
         end
         ST_RING_UPDATE: begin
            cmd.ring_update = 1'b1;
         end
         ST_MEAN_CHECK: begin
            cmd.mean_start = sts.filled_nonzero;
         end
         ST_MEAN_WAIT: begin
            cmd.load_held = sts.div_done;
         end
         ST_EMIT: begin
            cmd.load_out = sts.out_free;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* src/frame_rate_meter_core.sv */
// Frame rate meter, top level: stream ports, controller and datapath.
// Depends on frm_pkg, frm_ctrl and frm_dpath (which holds frm_div).
//
// Each input transaction is one frame tick: the microseconds elapsed since
// the previous tick and a pause flag. Every tick yields exactly one result
// transaction carrying the averaged frame rate in unsigned Q20.8 frames per
// second, the game time in microseconds (paused ticks add nothing; wraps at
// 2^48) and the number of ticks seen including this one (wraps at 2^32).
// A tick with a nonzero elapsed time stores the instantaneous rate,
// floor(256000000 / elapsed), in a ring of the last RING_DEPTH samples, and
// the reported rate is the floor of the mean of the filled slots. A tick with
// zero elapsed time stores nothing, and while the ring is still empty the
// rate reported is zero. The block works on one tick at a time. Both the
// sample and the mean come from one shared restoring divider that produces a
// quotient bit per cycle over the width of the running sum, 28 plus
// clog2(RING_DEPTH + 1) bits; a tick needs one division fewer when the elapsed
// time is zero. The result sits in an output register, so the next tick is
// accepted while the previous result still waits. The ring needs no clearing
// pass: a valid bit per slot, cleared by reset, marks the slots written so far.
module frame_rate_meter_core #(
   parameter int RING_DEPTH = frm_pkg::RING_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [23:0] elapsed_us
   input  logic [frm_pkg::REQ_DATA_W-1:0]  req_tdata,
   // [0] paused
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [27:0] rate_q8, [75:28] game_time_us, [107:76] frame_total, rest zero
   output logic [frm_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   import frm_pkg::*;

   cmd_type            cmd;
   sts_type            sts;
   logic [RATE_W-1:0]  rsp_rate_q8;
   logic [TIME_W-1:0]  rsp_game_time_us;
   logic [TOTAL_W-1:0] rsp_frame_total;

   // The controller steps through sample division, ring update, mean
   // division and hand-over to the output register.
   frm_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .sts(sts),
      .cmd(cmd)
   );

   frm_dpath #(
      .RING_DEPTH(RING_DEPTH)
   ) u_dpath (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .sts(sts),
      .req_elapsed_us(req_tdata[ELAPSED_W-1:0]),
      .req_paused(req_tuser),
      .rsp_tready(rsp_tready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_rate_q8(rsp_rate_q8),
      .rsp_game_time_us(rsp_game_time_us),
      .rsp_frame_total(rsp_frame_total)
   );

   // Pack the result fields, lowest field first, padded to whole bytes.
   assign rsp_tdata = RSP_DATA_W'({rsp_frame_total, rsp_game_time_us, rsp_rate_q8});

   // Once a tick is taken the block is busy with it on the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input accepted again straight after a tick was taken");

   // The output register is only loaded when its old result has gone.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_tvalid || rsp_tready))
      else $error("pending result overwritten");

   // The divider only finishes while a tick is being processed.
   a_div_in_flight: assert property (@(posedge clock) disable iff (reset)
      sts.div_done |-> !req_tready)
      else $error("divider finished while the block was idle");

   // Sample and mean divisions never start together.
   a_one_division: assert property (@(posedge clock) disable iff (reset)
      !(cmd.rate_start && cmd.mean_start))
      else $error("two divisions started in the same cycle");

endmodule
